FILE: hdl/page_frame_bitmap_allocator_macros.svh
// ----------------------------------------------------------------------------
// Page frame allocator assertion macros
// Shared macros for concurrent checks; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define PAGE_FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PFBA_ASSERT_IMPLY(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("allocator check failed: same-cycle implication");
`define PFBA_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("allocator check failed: next-cycle implication");
`else
`define PFBA_ASSERT_IMPLY(label, clk, rst, a, c)
`define PFBA_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

FILE: hdl/pfba_pkg.sv
// ----------------------------------------------------------------------------
// Page frame allocator package
// Beat types, action and status codes, and fixed bitmap word geometry.
// ----------------------------------------------------------------------------
package pfba_pkg;

  localparam int WORD_BITS   = 32;
  localparam int BIT_W       = 5;
  localparam int ADDR_W      = 64;
  localparam int CFG_INDEX_W = 1;

  localparam logic [BIT_W-1:0] WORD_MSB = 5'd31;

  localparam logic [1:0] ACT_ALLOC        = 2'd0;
  localparam logic [1:0] ACT_ALLOC_KERNEL = 2'd1;
  localparam logic [1:0] ACT_FREE         = 2'd2;
  localparam logic [1:0] ACT_RESERVE      = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_PHYS_BASE   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VIRT_OFFSET = 1'b1;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] range_end;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    logic [1:0]        status;
  } result_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic zero;
    logic set;
  } map_op_t;

  typedef struct packed {
    logic zero;
    logic in_frames;
    logic empty;
    logic fits;
  } chk_t;

endpackage

FILE: hdl/pfba_map.sv
// ----------------------------------------------------------------------------
// Page frame allocator bitmap memory
// Word-wide used map with registered read, masked write-back and a
// lowest-free-bit finder on the word last read.
// ----------------------------------------------------------------------------
module pfba_map #(
  parameter int  FRAME_COUNT = 1024,
  localparam int WORDS = (FRAME_COUNT + pfba_pkg::WORD_BITS - 1) / pfba_pkg::WORD_BITS,
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                                 clk,
  input  pfba_pkg::map_op_t                    op,
  input  logic [AW-1:0]                        rd_addr,
  input  logic [AW-1:0]                        wr_addr,
  input  logic [pfba_pkg::WORD_BITS-1:0]       mask,
  output logic [AW-1:0]                        rd_idx,
  output logic                                 found,
  output logic [pfba_pkg::BIT_W-1:0]           found_bit
);

  localparam int WB    = pfba_pkg::WORD_BITS;
  localparam int BW    = pfba_pkg::BIT_W;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam logic [WB-1:0] LAST_MASK = {WB{1'b1}} >> (WB * WORDS - FRAME_COUNT);

  logic [WB-1:0] mem [WORDS];
  logic [WB-1:0] rd_data;
  logic [WB-1:0] wr_data;
  logic [WB-1:0] free_bits;
  logic [WB-1:0] low_bit;

  always_comb begin
    if (op.zero) begin
      wr_data = '0;
    end else if (op.set) begin
      wr_data = rd_data | mask;
    end else begin
      wr_data = rd_data & ~mask;
    end
  end

  always_ff @(posedge clk) begin
    if (op.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (op.rd) begin
      rd_data <= mem[rd_addr];
      rd_idx  <= rd_addr;
    end
  end

  always_comb begin
    free_bits = ~rd_data & ((rd_idx == LAST_WORD) ? LAST_MASK : {WB{1'b1}});
    low_bit   = free_bits & (~free_bits + 1'b1);
    found     = |free_bits;
    found_bit = '0;
    for (int i = 0; i < WB; i++) begin
      if (low_bit[i]) begin
        found_bit = found_bit | BW'(i);
      end
    end
  end

endmodule

FILE: hdl/pfba_chk.sv
// ----------------------------------------------------------------------------
// Page frame allocator address check
// Two register stages that turn a free or reserve request into a frame
// range and its validity flags.
// ----------------------------------------------------------------------------
module pfba_chk #(
  parameter int  FRAME_COUNT = 1024,
  parameter int  PAGE_SHIFT  = 12,
  localparam int WORDS = (FRAME_COUNT + pfba_pkg::WORD_BITS - 1) / pfba_pkg::WORD_BITS,
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1,
  localparam int FXW   = AW + pfba_pkg::BIT_W
) (
  input  logic                            clk,
  input  logic [pfba_pkg::ADDR_W-1:0]     base,
  input  logic [pfba_pkg::ADDR_W-1:0]     address,
  input  logic [pfba_pkg::ADDR_W-1:0]     range_end,
  output pfba_pkg::chk_t                  flags,
  output logic [FXW-1:0]                  first,
  output logic [FXW-1:0]                  last
);

  localparam logic [FXW:0] FC_X = (FXW + 1)'(FRAME_COUNT);
  localparam logic [pfba_pkg::ADDR_W-1:0] FC_W = pfba_pkg::ADDR_W'(FRAME_COUNT);

  logic                          below;
  logic                          empty;
  logic                          zero;
  logic [pfba_pkg::ADDR_W-1:0]   diff;
  logic [pfba_pkg::ADDR_W-1:0]   span;
  logic [pfba_pkg::ADDR_W-1:0]   hi_diff;
  logic [pfba_pkg::ADDR_W-1:0]   span_frames;
  logic [FXW-1:0]                first_c;
  logic [FXW:0]                  end_sum;

  always_ff @(posedge clk) begin
    below <= address < base;
    empty <= address >= range_end;
    zero  <= address == '0;
    diff  <= address - base;
    span  <= range_end - address - 1'b1;
  end

  always_comb begin
    hi_diff     = diff >> PAGE_SHIFT;
    span_frames = span >> PAGE_SHIFT;
    first_c     = hi_diff[FXW-1:0];
    end_sum     = {1'b0, span_frames[FXW-1:0]} + {1'b0, first_c};
  end

  always_ff @(posedge clk) begin
    flags.zero      <= zero;
    flags.empty     <= empty;
    flags.in_frames <= !below && (hi_diff < FC_W);
    flags.fits      <= (span_frames < FC_W) && (end_sum < FC_X);
    first           <= first_c;
    last            <= first_c + span_frames[FXW-1:0];
  end

endmodule

FILE: hdl/page_frame_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// Page frame bitmap allocator
// First-fit allocator over a used bitmap of 32-bit words. Allocate reads the
// words in order from word 0 and sets the lowest free bit; free clears one
// bit; reserve sets a frame range one bitmap word at a time. A free or reserve
// that fails its check is rejected. One item at a time. After reset a clearing
// pass writes (FRAME_COUNT+31)/32 words, one per cycle, with busy high.
// Results are strobed on done and cannot be stalled.
// ----------------------------------------------------------------------------
`include "page_frame_bitmap_allocator_macros.svh"

module page_frame_bitmap_allocator #(
  parameter int FRAME_COUNT = 1024,
  parameter int PAGE_SHIFT  = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  pfba_pkg::item_t                     item,
  output logic                                done,
  output pfba_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pfba_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pfba_pkg::ADDR_W-1:0]         cfg_data
);

  localparam int WB    = pfba_pkg::WORD_BITS;
  localparam int BW    = pfba_pkg::BIT_W;
  localparam int WORDS = (FRAME_COUNT + WB - 1) / WB;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int FXW   = AW + BW;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  localparam logic [3:0] S_CLR    = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_CHK1   = 4'd2;
  localparam logic [3:0] S_CHK2   = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_ADDR1  = 4'd6;
  localparam logic [3:0] S_ADDR2  = 4'd7;
  localparam logic [3:0] S_RMW_RD = 4'd8;
  localparam logic [3:0] S_RMW_WR = 4'd9;

  logic [3:0]                   state, state_next;
  logic [AW-1:0]                clr_addr, clr_addr_next;
  logic [AW-1:0]                scan_addr, scan_addr_next;
  logic                         scan_more, scan_more_next;
  logic                         pend;
  logic [AW-1:0]                cur_word, cur_word_next;
  logic                         done_next;
  pfba_pkg::result_t            res_next;
  pfba_pkg::item_t              req;
  logic [FXW-1:0]               frame;
  logic [pfba_pkg::ADDR_W-1:0]  phys_addr;
  logic [pfba_pkg::ADDR_W-1:0]  phys_base;
  logic [pfba_pkg::ADDR_W-1:0]  virt_offset;

  pfba_pkg::map_op_t            map_op;
  logic [AW-1:0]                map_rd_addr;
  logic [AW-1:0]                map_wr_addr;
  logic [WB-1:0]                map_mask;
  logic [AW-1:0]                map_rd_idx;
  logic                         map_found;
  logic [BW-1:0]                map_found_bit;

  pfba_pkg::chk_t               chk;
  logic [FXW-1:0]               first;
  logic [FXW-1:0]               last;
  logic [WB-1:0]                lo_mask;
  logic [WB-1:0]                hi_mask;

  pfba_map #(
    .FRAME_COUNT (FRAME_COUNT)
  ) u_map (
    .clk       (clk),
    .op        (map_op),
    .rd_addr   (map_rd_addr),
    .wr_addr   (map_wr_addr),
    .mask      (map_mask),
    .rd_idx    (map_rd_idx),
    .found     (map_found),
    .found_bit (map_found_bit)
  );

  pfba_chk #(
    .FRAME_COUNT (FRAME_COUNT),
    .PAGE_SHIFT  (PAGE_SHIFT)
  ) u_chk (
    .clk       (clk),
    .base      (phys_base),
    .address   (req.address),
    .range_end (req.range_end),
    .flags     (chk),
    .first     (first),
    .last      (last)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    lo_mask = (cur_word == first[FXW-1:BW]) ? ({WB{1'b1}} << first[BW-1:0]) : {WB{1'b1}};
    hi_mask = (cur_word == last[FXW-1:BW])
            ? ({WB{1'b1}} >> (pfba_pkg::WORD_MSB - last[BW-1:0])) : {WB{1'b1}};
  end

  always_comb begin
    state_next     = state;
    clr_addr_next  = clr_addr;
    scan_addr_next = scan_addr;
    scan_more_next = scan_more;
    cur_word_next  = cur_word;
    done_next      = 1'b0;
    res_next       = result;
    map_op         = '0;
    map_rd_addr    = scan_addr;
    map_wr_addr    = cur_word;
    map_mask       = '0;
    case (state)
      S_CLR: begin
        map_op.wr   = 1'b1;
        map_op.zero = 1'b1;
        map_wr_addr = clr_addr;
        if (clr_addr == LAST_WORD) begin
          state_next = S_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (item.action)
            pfba_pkg::ACT_ALLOC, pfba_pkg::ACT_ALLOC_KERNEL: begin
              state_next     = S_SCAN;
              scan_addr_next = '0;
              scan_more_next = 1'b1;
            end
            default: begin
              state_next = S_CHK1;
            end
          endcase
        end
      end
      S_CHK1: begin
        state_next = S_CHK2;
      end
      S_CHK2: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cur_word_next = first[FXW-1:BW];
        if (req.action == pfba_pkg::ACT_FREE) begin
          if (chk.zero) begin
            state_next = S_IDLE;
            done_next  = 1'b1;
            res_next   = '{page_address: '0, status: pfba_pkg::ST_OK};
          end else if (!chk.in_frames) begin
            state_next = S_IDLE;
            done_next  = 1'b1;
            res_next   = '{page_address: '0, status: pfba_pkg::ST_BAD};
          end else begin
            state_next = S_RMW_RD;
          end
        end else if (chk.empty || !chk.in_frames || !chk.fits) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          res_next   = '{page_address: '0, status: pfba_pkg::ST_BAD};
        end else begin
          state_next = S_RMW_RD;
        end
      end
      S_RMW_RD: begin
        map_op.rd   = 1'b1;
        map_rd_addr = cur_word;
        state_next  = S_RMW_WR;
      end
      S_RMW_WR: begin
        map_op.wr   = 1'b1;
        map_op.set  = (req.action == pfba_pkg::ACT_RESERVE);
        map_wr_addr = cur_word;
        if (req.action == pfba_pkg::ACT_FREE) begin
          map_mask = WB'(1) << first[BW-1:0];
        end else begin
          map_mask = lo_mask & hi_mask;
        end
        if ((req.action == pfba_pkg::ACT_FREE) || (cur_word == last[FXW-1:BW])) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          res_next   = '{page_address: '0, status: pfba_pkg::ST_OK};
        end else begin
          cur_word_next = cur_word + 1'b1;
          state_next    = S_RMW_RD;
        end
      end
      S_SCAN: begin
        map_op.rd   = scan_more;
        map_rd_addr = scan_addr;
        if (scan_more) begin
          if (scan_addr == LAST_WORD) begin
            scan_more_next = 1'b0;
          end else begin
            scan_addr_next = scan_addr + 1'b1;
          end
        end
        if (pend && map_found) begin
          map_op.wr   = 1'b1;
          map_op.set  = 1'b1;
          map_wr_addr = map_rd_idx;
          map_mask    = WB'(1) << map_found_bit;
          state_next  = S_ADDR1;
        end else if (pend && (map_rd_idx == LAST_WORD)) begin
          state_next = S_IDLE;
          done_next  = 1'b1;
          res_next   = '{page_address: '0, status: pfba_pkg::ST_NOMEM};
        end
      end
      S_ADDR1: begin
        state_next = S_ADDR2;
      end
      S_ADDR2: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        res_next.status = pfba_pkg::ST_OK;
        if ((req.action == pfba_pkg::ACT_ALLOC_KERNEL) && (phys_addr != '0)) begin
          res_next.page_address = phys_addr + virt_offset;
        end else begin
          res_next.page_address = phys_addr;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_addr  <= '0;
      scan_addr <= '0;
      scan_more <= 1'b0;
      pend      <= 1'b0;
      cur_word  <= '0;
      done      <= 1'b0;
    end else begin
      state     <= state_next;
      clr_addr  <= clr_addr_next;
      scan_addr <= scan_addr_next;
      scan_more <= scan_more_next;
      pend      <= (state == S_SCAN) && scan_more;
      cur_word  <= cur_word_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
    if (start && !busy) begin
      req <= item;
    end
    if (state == S_SCAN) begin
      frame <= {map_rd_idx, map_found_bit};
    end
    phys_addr <= phys_base + (pfba_pkg::ADDR_W'(frame) << PAGE_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phys_base   <= '0;
      virt_offset <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pfba_pkg::CFG_PHYS_BASE:   phys_base   <= cfg_data;
        pfba_pkg::CFG_VIRT_OFFSET: virt_offset <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  `PFBA_ASSERT_IMPLY(a_done_when_idle, clk, rst, done, !busy)
  `PFBA_ASSERT_NEXT(a_accept_goes_busy, clk, rst, start && !busy, busy)
  `PFBA_ASSERT_IMPLY(a_fail_gives_zero, clk, rst, done && (result.status != pfba_pkg::ST_OK), result.page_address == '0)
  `PFBA_ASSERT_IMPLY(a_idle_no_write, clk, rst, state == S_IDLE, !map_op.wr)

endmodule

FILE: test/page_frame_bitmap_allocator_test.sv
// ----------------------------------------------------------------------------
// Page frame bitmap allocator testbench
// Drives allocate, free and reserve requests through the command port and
// checks every strobed result against a first-fit bitmap predictor kept in
// step with the block, or a typed row's table value. A directed table covers
// corner cases, then random phases vary frame base, kernel offset and idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module page_frame_bitmap_allocator_test;

  localparam int ADDR_W = pfba_pkg::ADDR_W;
  localparam int FRAMES = 1024;
  localparam int SHIFT = 12;
  localparam int PAGE_BYTES = 1 << SHIFT;
  localparam int ROUNDS = 6;
  localparam int ROUND_ITEMS = 272;
  localparam int SETTLE_CYCLES = 2 * (FRAMES / 32) + 40;
  localparam logic [ADDR_W-1:0] KERNEL_BASE = 64'hFFFF_8000_0000_0000;
  localparam logic [ADDR_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    pfba_pkg::item_t   req;
    logic              typed;
    pfba_pkg::result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  pfba_pkg::item_t item = '0;
  logic done;
  pfba_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pfba_pkg::CFG_INDEX_W-1:0] cfg_index = pfba_pkg::CFG_PHYS_BASE;
  logic [ADDR_W-1:0] cfg_data = '0;

  logic typed_on = 1'b0;
  pfba_pkg::result_t typed_want = '0;

  logic frame_used [FRAMES];
  logic [ADDR_W-1:0] model_base = '0;
  logic [ADDR_W-1:0] model_offset = '0;
  pfba_pkg::result_t pending_results [$];
  stim_row_t directed_rows [$];

  int mismatches = 0;
  int n_alloc = 0;
  int n_free = 0;
  int n_reserve = 0;
  int n_ok = 0;
  int n_nomem = 0;
  int n_bad = 0;
  int n_settings = 0;

  always #5 clk = ~clk;

  page_frame_bitmap_allocator #(
    .FRAME_COUNT(FRAMES),
    .PAGE_SHIFT (SHIFT)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    for (int i = 0; i < FRAMES; i++) frame_used[i] = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("%0t ns: mismatch on %s, got %h, expected %h", $time, what, got, want);
    end
  endtask

  function automatic bit locate_frame(input logic [ADDR_W-1:0] addr, output int unsigned idx);
    logic [ADDR_W-1:0] rel;
    rel = (addr - model_base) >> SHIFT;
    idx = rel[31:0];
    return (addr >= model_base) && (rel < ADDR_W'(FRAMES));
  endfunction

  task automatic apply_request(input pfba_pkg::item_t req, output pfba_pkg::result_t res);
    logic [ADDR_W-1:0] span;
    int unsigned first;
    int found;
    res.page_address = '0;
    res.status = pfba_pkg::ST_OK;
    first = 0;
    case (req.action)
      pfba_pkg::ACT_ALLOC, pfba_pkg::ACT_ALLOC_KERNEL: begin
        found = -1;
        for (int i = 0; i < FRAMES; i++) begin
          if (!frame_used[i]) begin
            found = i;
            break;
          end
        end
        if (found < 0) begin
          res.status = pfba_pkg::ST_NOMEM;
        end else begin
          frame_used[found] = 1'b1;
          res.page_address = model_base + (ADDR_W'(found) << SHIFT);
          if (req.action == pfba_pkg::ACT_ALLOC_KERNEL && res.page_address != '0) begin
            res.page_address = res.page_address + model_offset;
          end
        end
      end
      pfba_pkg::ACT_FREE: begin
        if (req.address != '0) begin
          if (locate_frame(req.address, first)) frame_used[first] = 1'b0;
          else res.status = pfba_pkg::ST_BAD;
        end
      end
      default: begin
        span = ((req.range_end - req.address - 1) >> SHIFT) + 1;
        if (req.address >= req.range_end || !locate_frame(req.address, first) ||
            span > ADDR_W'(FRAMES - first)) begin
          res.status = pfba_pkg::ST_BAD;
        end else begin
          for (int unsigned j = 0; j < span; j++) frame_used[first + j] = 1'b1;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    pfba_pkg::result_t predicted;
    pfba_pkg::result_t oldest;
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", result.page_address, '0);
        end else begin
          oldest = pending_results.pop_front();
          if (result.page_address !== oldest.page_address) begin
            report_mismatch("page_address", result.page_address, oldest.page_address);
          end
          if (result.status !== oldest.status) begin
            report_mismatch("status", ADDR_W'(result.status), ADDR_W'(oldest.status));
          end
          case (result.status)
            pfba_pkg::ST_OK:    n_ok++;
            pfba_pkg::ST_NOMEM: n_nomem++;
            default:            n_bad++;
          endcase
        end
      end
      if (start && !busy) begin
        apply_request(item, predicted);
        pending_results.push_back(typed_on ? typed_want : predicted);
        case (item.action)
          pfba_pkg::ACT_FREE:    n_free++;
          pfba_pkg::ACT_RESERVE: n_reserve++;
          default:               n_alloc++;
        endcase
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pfba_pkg::CFG_PHYS_BASE:   model_base = cfg_data;
          pfba_pkg::CFG_VIRT_OFFSET: model_offset = cfg_data;
          default: ;
        endcase
      end
    end
  end

  task automatic write_register(input logic [pfba_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [ADDR_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // A request beat is taken at the first rising edge that sees start with busy low.
  task automatic send_request(input pfba_pkg::item_t req, input logic typed,
                              input pfba_pkg::result_t want, input int idle_pct);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    item <= req;
    typed_on <= typed;
    typed_want <= want;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic stim_row_t mk_row(input logic [1:0] action, input logic [ADDR_W-1:0] addr,
                                       input logic [ADDR_W-1:0] range_end, input logic typed,
                                       input logic [ADDR_W-1:0] page, input logic [1:0] status);
    stim_row_t row;
    row.req.action = action;
    row.req.address = addr;
    row.req.range_end = range_end;
    row.typed = typed;
    row.want.page_address = page;
    row.want.status = status;
    return row;
  endfunction

  function automatic pfba_pkg::item_t random_request(input logic [ADDR_W-1:0] base);
    pfba_pkg::item_t r;
    int unsigned pick;
    int unsigned idx;
    int unsigned len;
    logic [ADDR_W-1:0] frame_addr;
    pick = $urandom_range(99);
    idx = $urandom_range(FRAMES - 1);
    frame_addr = base + (ADDR_W'(idx) << SHIFT);
    r.address = frame_addr;
    if ($urandom_range(3) == 0) r.address = frame_addr + ADDR_W'($urandom_range(PAGE_BYTES - 1));
    r.range_end = {$urandom, $urandom};
    if (pick < 40) begin
      r.action = $urandom_range(1) ? pfba_pkg::ACT_ALLOC_KERNEL : pfba_pkg::ACT_ALLOC;
    end else if (pick < 72) begin
      r.action = pfba_pkg::ACT_FREE;
    end else if (pick < 88) begin
      r.action = pfba_pkg::ACT_RESERVE;
      len = $urandom_range(24);
      if ($urandom_range(15) == 0) len = $urandom_range(FRAMES + 8);
      if (len == 0) r.range_end = r.address;
      else r.range_end = frame_addr + (ADDR_W'(len - 1) << SHIFT) +
                         ADDR_W'($urandom_range(PAGE_BYTES, 1));
    end else if (pick < 90) begin
      r.action = pfba_pkg::ACT_RESERVE;
      r.address = base;
      r.range_end = base + (ADDR_W'(FRAMES) << SHIFT);
    end else begin
      r.action = 2'($urandom_range(3));
      case ($urandom_range(2))
        0: r.address = {$urandom, $urandom};
        1: r.address = base - ADDR_W'($urandom_range(4 * PAGE_BYTES, 1));
        default: r.address = base + (ADDR_W'(FRAMES) << SHIFT) + ADDR_W'($urandom_range(4096));
      endcase
      if ($urandom_range(1)) r.range_end = r.address + ADDR_W'($urandom_range(8 * PAGE_BYTES));
    end
    return r;
  endfunction

  initial begin
    logic [ADDR_W-1:0] bases [ROUNDS];
    logic [ADDR_W-1:0] offsets [ROUNDS];
    int idle [ROUNDS];
    stim_row_t row;
    pfba_pkg::result_t none;
    none = '0;

    directed_rows.push_back(mk_row(pfba_pkg::ACT_ALLOC_KERNEL, '0, ALL_ONES, 1, '0,
                                   pfba_pkg::ST_OK));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_ALLOC, '0, '0, 1, 64'h1000, pfba_pkg::ST_OK));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_ALLOC_KERNEL, ALL_ONES, '0, 1,
                                   KERNEL_BASE + 64'h2000, pfba_pkg::ST_OK));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_FREE, '0, '0, 1, '0, pfba_pkg::ST_OK));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_FREE, 64'h1000, ALL_ONES, 1, '0,
                                   pfba_pkg::ST_OK));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_FREE, 64'h1000, '0, 1, '0, pfba_pkg::ST_OK));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_ALLOC, '0, '0, 0, '0, pfba_pkg::ST_OK));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_FREE, 64'h2FFF, '0, 0, '0, pfba_pkg::ST_OK));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_FREE, ALL_ONES, ALL_ONES, 1, '0,
                                   pfba_pkg::ST_BAD));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_FREE, 64'h40_0000, '0, 1, '0,
                                   pfba_pkg::ST_BAD));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_FREE, 64'h3F_FFFF, '0, 0, '0,
                                   pfba_pkg::ST_OK));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_RESERVE, 64'h5000, 64'h5000, 1, '0,
                                   pfba_pkg::ST_BAD));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_RESERVE, ALL_ONES, '0, 1, '0,
                                   pfba_pkg::ST_BAD));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_RESERVE, 64'h3F_F000, 64'h40_1000, 1, '0,
                                   pfba_pkg::ST_BAD));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_RESERVE, 64'h40_0000, 64'h50_0000, 1, '0,
                                   pfba_pkg::ST_BAD));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_RESERVE, '0, ALL_ONES, 1, '0,
                                   pfba_pkg::ST_BAD));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_RESERVE, 64'h3F_F000, 64'h40_0000, 0, '0,
                                   pfba_pkg::ST_OK));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_RESERVE, '0, 64'h40_0000, 1, '0,
                                   pfba_pkg::ST_OK));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_ALLOC, '0, '0, 1, '0, pfba_pkg::ST_NOMEM));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_ALLOC_KERNEL, '0, '0, 1, '0,
                                   pfba_pkg::ST_NOMEM));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_FREE, 64'h3F_F800, '0, 0, '0,
                                   pfba_pkg::ST_OK));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_ALLOC_KERNEL, '0, '0, 0, '0, pfba_pkg::ST_OK));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_FREE, 64'h2_0000, '0, 0, '0, pfba_pkg::ST_OK));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_RESERVE, 64'h2_0000, 64'h2_0001, 0, '0,
                                   pfba_pkg::ST_OK));
    directed_rows.push_back(mk_row(pfba_pkg::ACT_ALLOC, '0, '0, 1, '0, pfba_pkg::ST_NOMEM));

    bases[0] = 64'h0000_0000_8000_0000;  offsets[0] = KERNEL_BASE;         idle[0] = 0;
    bases[1] = 64'hFFFF_FFFF_FFC0_0000;  offsets[1] = ALL_ONES;            idle[1] = 49;
    bases[2] = 64'hFFFF_FFFF_FFF0_0000;  offsets[2] = {$urandom, $urandom}; idle[2] = 13;
    bases[3] = {$urandom, $urandom} & ~ADDR_W'(PAGE_BYTES - 1);
    offsets[3] = {$urandom, $urandom};                                     idle[3] = 0;
    bases[4] = {$urandom, $urandom};     offsets[4] = '0;                  idle[4] = 49;
    bases[5] = '0;                       offsets[5] = 64'hFFFF_FFFF_FFFF_F000; idle[5] = 13;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_register(pfba_pkg::CFG_VIRT_OFFSET, KERNEL_BASE);
    n_settings++;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.req, row.typed, row.want, 0);
    end
    drain_results();

    for (int r = 0; r < ROUNDS; r++) begin
      write_register(pfba_pkg::CFG_PHYS_BASE, bases[r]);
      write_register(pfba_pkg::CFG_VIRT_OFFSET, offsets[r]);
      n_settings++;
      for (int k = 0; k < ROUND_ITEMS; k++) begin
        send_request(random_request(bases[r]), 1'b0, none, idle[r]);
      end
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      report_mismatch("results never produced", ADDR_W'(pending_results.size()), '0);
    end
    $display("Run covered %0d allocations, %0d frees and %0d reserves under %0d settings.",
             n_alloc, n_free, n_reserve, n_settings);
    $display("Results seen: %0d ok, %0d out of memory, %0d rejected; %0d mismatches.",
             n_ok, n_nomem, n_bad, mismatches);
    if (mismatches == 0) begin
      $display("page_frame_bitmap_allocator_test: PASS");
    end else begin
      $display("page_frame_bitmap_allocator_test: FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", pending_results.size());
    $display("page_frame_bitmap_allocator_test: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/pfba_pkg.sv
hdl/pfba_map.sv
hdl/pfba_chk.sv
hdl/page_frame_bitmap_allocator.sv
test/page_frame_bitmap_allocator_test.sv
